@@ src/height_profile_interpolator_top_assert.svh @@
`ifndef HEIGHT_PROFILE_INTERPOLATOR_TOP_ASSERT_SVH
`define HEIGHT_PROFILE_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication on clk, off while rst is high.
`define HPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst is high.
`define HPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hpi_pkg.sv @@
package hpi_pkg;

  localparam int POS_W       = 32;
  localparam int GRAV_W      = 16;
  localparam int HGT_W       = 32;
  localparam int TEMP_W      = 20;
  localparam int LVL_W       = 5;
  localparam int ENTRY_IDX_W = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int FRAC_SHIFT  = 14;
  localparam int ROUND_BIAS  = 1 << (FRAC_SHIFT - 1);
  localparam int PROD_W      = POS_W + GRAV_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int H_W         = SUM_W - FRAC_SHIFT;
  localparam int WPROD_W     = TEMP_W + HGT_W;
  localparam int NUM_W       = WPROD_W + 1;
  localparam int REM_W       = NUM_W - TEMP_W;

  localparam int LEVELS_DEFAULT = 16;

  localparam logic signed [GRAV_W-1:0] GRAV_X_RESET = 16'sd0;
  localparam logic signed [GRAV_W-1:0] GRAV_Y_RESET = 16'sd0;
  localparam logic signed [GRAV_W-1:0] GRAV_Z_RESET = -16'sd16384;
  localparam logic [LVL_W-1:0]         LEVEL_COUNT_RESET = 5'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAV_X      = 2'd0,
    CFG_GRAV_Y      = 2'd1,
    CFG_GRAV_Z      = 2'd2,
    CFG_LEVEL_COUNT = 2'd3
  } cfg_index_t;

  // Search token walking the cell chain.
  typedef struct packed {
    logic                     valid;
    logic                     found;
    logic signed [H_W-1:0]    h;
    logic signed [HGT_W-1:0]  lo;
    logic signed [HGT_W-1:0]  hi;
    logic [TEMP_W-1:0]        t0;
    logic [TEMP_W-1:0]        t1;
  } hpi_token_t;

endpackage

@@ src/hpi_cell.sv @@
module hpi_cell
  import hpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic signed [HGT_W-1:0] wr_height,
  input  logic [TEMP_W-1:0]       wr_temp,
  input  logic                    seg_en,
  input  logic signed [HGT_W-1:0] next_height,
  input  logic [TEMP_W-1:0]       next_temp,
  output logic signed [HGT_W-1:0] height,
  output logic [TEMP_W-1:0]       temp,
  input  hpi_token_t              tok_in,
  output hpi_token_t              tok_out
);

  logic signed [H_W-1:0] lo_ext;
  logic signed [H_W-1:0] hi_ext;
  logic                  hit;
  hpi_token_t            tok_next;

  assign lo_ext = H_W'(height);
  assign hi_ext = H_W'(next_height);

  // First segment in index order wins: claim only an unclaimed token.
  assign hit = tok_in.valid && !tok_in.found && seg_en &&
               ($signed(tok_in.h) >= lo_ext) && ($signed(tok_in.h) <= hi_ext);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.lo    = height;
      tok_next.hi    = next_height;
      tok_next.t0    = temp;
      tok_next.t1    = next_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      height <= wr_height;
      temp   <= wr_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ src/hpi_div.sv @@
module hpi_div
  import hpi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [NUM_W-1:0]    dividend,
  input  logic [HGT_W-1:0]    divisor,
  output logic                done,
  output logic [TEMP_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(TEMP_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TEMP_W - 1);

  logic [REM_W-1:0]  rem;
  logic [TEMP_W-1:0] quo;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [REM_W:0]    trial;
  logic              ge;

  // Quotient fits TEMP_W bits, so the upper dividend bits start below the divisor.
  assign trial    = {rem, quo[TEMP_W-1]};
  assign ge       = trial >= (REM_W + 1)'(divisor);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= dividend[NUM_W-1:TEMP_W];
      quo  <= dividend[TEMP_W-1:0];
      step <= '0;
    end else if (busy) begin
      rem  <= ge ? REM_W'(trial - (REM_W + 1)'(divisor)) : trial[REM_W-1:0];
      quo  <= {quo[TEMP_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

endmodule

@@ src/height_profile_interpolator_top.sv @@
// Load transfer: written into its cell as it is taken, next item taken the cycle after.
// Query: the position is registered, projected onto gravity and rounded to a height;
// the token walks the LEVELS cells; a nonzero-length segment uses the 20-step radix-2
// divider. A new item waits until the result is in the output register.
// rst (synchronous) clears control, output valid and config to defaults; the
// breakpoint cells are not cleared and hold garbage until loaded.
module height_profile_interpolator_top
  import hpi_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [ENTRY_IDX_W-1:0]       entry_index,
  input  logic signed [HGT_W-1:0]      entry_height,
  input  logic [TEMP_W-1:0]            entry_temperature,
  input  logic signed [POS_W-1:0]      pos_x,
  input  logic signed [POS_W-1:0]      pos_y,
  input  logic signed [POS_W-1:0]      pos_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [TEMP_W-1:0]            temperature,
  output logic                         out_of_range
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MUL    = 11'b000_0000_0010,
    S_SUM    = 11'b000_0000_0100,
    S_HGT    = 11'b000_0000_1000,
    S_LAUNCH = 11'b000_0001_0000,
    S_SEARCH = 11'b000_0010_0000,
    S_DIFF   = 11'b000_0100_0000,
    S_PROD   = 11'b000_1000_0000,
    S_ADD    = 11'b001_0000_0000,
    S_DIV    = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic signed [GRAV_W-1:0] grav_x;
  logic signed [GRAV_W-1:0] grav_y;
  logic signed [GRAV_W-1:0] grav_z;
  logic [LVL_W-1:0]         level_count;

  // Handshake
  logic load_fire;
  logic query_fire;
  logic out_free;

  // Projection datapath
  logic signed [POS_W-1:0]  pos_x_q;
  logic signed [POS_W-1:0]  pos_y_q;
  logic signed [POS_W-1:0]  pos_z_q;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  neg_sum;
  logic signed [H_W-1:0]    h_q;

  // Cell chain
  hpi_token_t               chain_head;
  hpi_token_t               chain [LEVELS];
  hpi_token_t               chain_out;
  logic signed [HGT_W-1:0]  cell_height [LEVELS];
  logic [TEMP_W-1:0]        cell_temp [LEVELS];

  // Interpolation datapath
  hpi_token_t               seg_q;
  logic signed [H_W-1:0]    seg_lo_ext;
  logic signed [H_W-1:0]    seg_hi_ext;
  logic signed [H_W-1:0]    diff_hi;
  logic signed [H_W-1:0]    diff_lo;
  logic signed [H_W-1:0]    diff_den;
  logic [HGT_W-1:0]         d_hi_q;
  logic [HGT_W-1:0]         d_lo_q;
  logic [HGT_W-1:0]         den_q;
  logic [WPROD_W-1:0]       wt_lo_q;
  logic [WPROD_W-1:0]       wt_hi_q;
  logic [NUM_W-1:0]         num_q;
  logic                     div_go;
  logic                     div_done;
  logic [TEMP_W-1:0]        div_quo;

  // Result waiting for the output register
  logic [TEMP_W-1:0]        res_temp;
  logic                     res_oor;

  // Take a new item only from idle; the output register decouples the result side.
  assign in_stall   = (state != S_IDLE);
  assign load_fire  = in_valid && !in_stall && (kind == KIND_LOAD);
  assign query_fire = in_valid && !in_stall && (kind == KIND_QUERY);
  assign out_free   = !out_valid || !out_stall;

  // Configuration writes; each of the four indices selects one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_x      <= GRAV_X_RESET;
      grav_y      <= GRAV_Y_RESET;
      grav_z      <= GRAV_Z_RESET;
      level_count <= LEVEL_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRAV_X:      grav_x      <= cfg_data;
        CFG_GRAV_Y:      grav_y      <= cfg_data;
        CFG_GRAV_Z:      grav_z      <= cfg_data;
        CFG_LEVEL_COUNT: level_count <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          state_next = S_MUL;
        end
      end
      S_MUL:    state_next = S_SUM;
      S_SUM:    state_next = S_HGT;
      S_HGT:    state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_SEARCH;
      S_SEARCH: begin
        // Hold until the token leaves the last cell.
        if (chain_out.valid) begin
          state_next = chain_out.found ? S_DIFF : S_DONE;
        end
      end
      S_DIFF:   state_next = S_PROD;
      S_PROD:   state_next = (den_q == '0) ? S_DONE : S_ADD;
      S_ADD:    state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result while the output register is still occupied.
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Projection: h = round(-(p . g) / 2^14), ties toward plus infinity, full width.
  assign neg_sum = SUM_W'(ROUND_BIAS) - sum_q;

  // Segment differences; all non-negative and below 2^32 once a segment holds h.
  assign seg_lo_ext = H_W'(seg_q.lo);
  assign seg_hi_ext = H_W'(seg_q.hi);
  assign diff_hi    = seg_hi_ext - h_q;
  assign diff_lo    = h_q - seg_lo_ext;
  assign diff_den   = seg_hi_ext - seg_lo_ext;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          pos_x_q <= pos_x;
          pos_y_q <= pos_y;
          pos_z_q <= pos_z;
        end
      end
      S_MUL: begin
        prod_x <= PROD_W'(pos_x_q) * PROD_W'(grav_x);
        prod_y <= PROD_W'(pos_y_q) * PROD_W'(grav_y);
        prod_z <= PROD_W'(pos_z_q) * PROD_W'(grav_z);
      end
      S_SUM: begin
        sum_q <= SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z);
      end
      S_HGT: begin
        h_q <= $signed(neg_sum[SUM_W-1:FRAC_SHIFT]);
      end
      S_SEARCH: begin
        if (chain_out.valid) begin
          seg_q <= chain_out;
          if (!chain_out.found) begin
            res_temp <= '0;
            res_oor  <= 1'b1;
          end
        end
      end
      S_DIFF: begin
        d_hi_q <= diff_hi[HGT_W-1:0];
        d_lo_q <= diff_lo[HGT_W-1:0];
        den_q  <= diff_den[HGT_W-1:0];
      end
      S_PROD: begin
        // Zero-length segment: return the lower temperature.
        res_temp <= seg_q.t0;
        res_oor  <= 1'b0;
        wt_lo_q  <= WPROD_W'(seg_q.t0) * WPROD_W'(d_hi_q);
        wt_hi_q  <= WPROD_W'(seg_q.t1) * WPROD_W'(d_lo_q);
      end
      S_ADD: begin
        // Add half the span so the divide rounds to nearest, ties upward.
        num_q <= NUM_W'(wt_lo_q) + NUM_W'(wt_hi_q) + NUM_W'(den_q >> 1);
      end
      S_DIV: begin
        if (div_done) begin
          res_temp <= div_quo;
          res_oor  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= (state == S_ADD);
    end
  end

  hpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (num_q),
    .divisor  (den_q),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Launch the search token into cell 0 for one cycle.
  always_comb begin
    chain_head       = '0;
    chain_head.valid = (state == S_LAUNCH);
    chain_head.h     = h_q;
  end

  assign chain_out = chain[LEVELS-1];

  // Cell i holds breakpoint i and tests segment [i, i+1] as the token passes.
  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    hpi_token_t              tok_in_w;
    logic signed [HGT_W-1:0] nb_height;
    logic [TEMP_W-1:0]       nb_temp;
    logic                    seg_en;
    logic                    wr_sel;

    if (i == 0) begin : g_head
      assign tok_in_w = chain_head;
    end else begin : g_link
      assign tok_in_w = chain[i-1];
    end

    if (i < LEVELS - 1) begin : g_mid
      assign nb_height = cell_height[i+1];
      assign nb_temp   = cell_temp[i+1];
      assign seg_en    = (32'(level_count) > 32'(i + 1));
    end else begin : g_last
      // Last breakpoint starts no segment.
      assign nb_height = '0;
      assign nb_temp   = '0;
      assign seg_en    = 1'b0;
    end

    // Loads to slots at or above LEVELS match no cell and are dropped.
    assign wr_sel = load_fire && (32'(entry_index) == 32'(i));

    hpi_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .wr_en       (wr_sel),
      .wr_height   (entry_height),
      .wr_temp     (entry_temperature),
      .seg_en      (seg_en),
      .next_height (nb_height),
      .next_temp   (nb_temp),
      .height      (cell_height[i]),
      .temp        (cell_temp[i]),
      .tok_in      (tok_in_w),
      .tok_out     (chain[i])
    );
  end

  // Output register: advance on transfer, load when the sequencer finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      temperature  <= res_temp;
      out_of_range <= res_oor;
    end
  end

endmodule

@@ src/hpi_checker.sv @@
`include "height_profile_interpolator_top_assert.svh"

module hpi_checker
  import hpi_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              kind,
  input logic              out_valid,
  input logic              out_stall,
  input logic [TEMP_W-1:0] temperature,
  input logic              out_of_range
);

  `HPI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(temperature) && $stable(out_of_range), "stalled result changed")
  `HPI_ASSERT_NOW(a_oor_zero, out_valid && out_of_range, temperature == '0, "out-of-range result with nonzero temperature")
  `HPI_ASSERT_NEXT(a_load_ready, in_valid && !in_stall && (kind == KIND_LOAD), !in_stall, "load transfer blocked the input")
  `HPI_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (kind == KIND_QUERY), in_stall, "query transfer left the input open")
  `HPI_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result appeared without a query in flight")

endmodule

bind height_profile_interpolator_top hpi_checker u_hpi_checker (.*);
